[rtl/rbc_pkg.sv]
// Shared types, codes and backoff tables for the reconnect backoff controller.
package rbc_pkg;

  localparam int BACKOFF_STEPS = 6;

  localparam int FUNC_W  = 3;
  localparam int CODE_W  = 16;
  localparam int TIME_W  = 32;
  localparam int RND_W   = 32;
  localparam int MODE_W  = 3;
  localparam int STEP_W  = 3;
  localparam int HB_W    = 22;
  localparam int DELAY_W = 15;
  localparam int REM_W   = 14;
  localparam int OFS_W   = 16;

  // Remainder unit consumes this many random bits per cycle.
  localparam int DIGIT_W   = 4;
  localparam int DIGITS    = RND_W / DIGIT_W;
  localparam int DIGCNT_W  = $clog2(DIGITS);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(BACKOFF_STEPS - 1);
  localparam logic [HB_W-1:0]   HB_RESET  = HB_W'(15000);

  localparam logic [FUNC_W-1:0] FUNC_OPENED  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLOSED  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CONNECT = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_START   = 3'd4;

  localparam logic [MODE_W-1:0] MODE_DISCONNECTED = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CONNECTING   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CONNECTED    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BACKOFF      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FATAL        = 3'd4;

  localparam logic [CODE_W-1:0] CLOSE_FATAL_A = 16'd4401;
  localparam logic [CODE_W-1:0] CLOSE_FATAL_B = 16'd4402;
  localparam logic [CODE_W-1:0] CLOSE_FATAL_C = 16'd4426;

  localparam logic [DELAY_W-1:0] DELAY_TABLE [8] = '{
    15'd2000, 15'd4000, 15'd8000, 15'd16000,
    15'd30000, 15'd30000, 15'd30000, 15'd30000
  };

  typedef struct packed {
    logic capture;
    logic mod_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_mod;
    logic mod_last;
  } dp_status_t;

  function automatic logic [DELAY_W-1:0] delay_base(input logic [STEP_W-1:0] idx);
    return DELAY_TABLE[idx];
  endfunction

  // Jitter modulus 2*(base/4)+1.
  function automatic logic [REM_W-1:0] jitter_mod(input logic [STEP_W-1:0] idx);
    logic [DELAY_W-1:0] base;
    base = DELAY_TABLE[idx];
    return {base[DELAY_W-1:2], 1'b1};
  endfunction

endpackage

[rtl/rbc_ctrl.sv]
// Sequencing state machine for the reconnect backoff controller.
module rbc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  rbc_pkg::dp_status_t status,
  output rbc_pkg::dp_cmd_t    cmd
);
  import rbc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MOD  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state, state_next;
  logic       out_valid, out_valid_next;
  logic       out_free;

  assign out_free = !out_valid || m_tready;
  // No transfer is taken while reset is held.
  assign s_tready = (state == ST_IDLE) && !rst;
  assign m_tvalid = out_valid;

  always_comb begin
    state_next   = state;
    cmd.capture  = 1'b0;
    cmd.mod_step = 1'b0;
    cmd.commit   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.capture = 1'b1;
          state_next  = ST_MOD;
        end
      end
      ST_MOD: begin
        if (!status.need_mod) begin
          state_next = ST_FIN;
        end else begin
          cmd.mod_step = 1'b1;
          if (status.mod_last) state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        // The state update and the result go out together once the slot is free.
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid && !m_tready;
    if (cmd.commit) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[rtl/rbc_datapath.sv]
// Link state, deadlines, jitter remainder unit and result register.
module rbc_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rbc_pkg::FUNC_W-1:0]    in_func,
  input  logic                          in_present,
  input  logic [rbc_pkg::CODE_W-1:0]    in_code,
  input  logic [rbc_pkg::TIME_W-1:0]    in_now,
  input  logic [rbc_pkg::RND_W-1:0]     in_rnd,
  input  logic                          cfg_we,
  input  logic [rbc_pkg::HB_W-1:0]      cfg_data,
  input  rbc_pkg::dp_cmd_t              cmd,
  output rbc_pkg::dp_status_t           status,
  output logic [rbc_pkg::MODE_W-1:0]    out_state,
  output logic                          out_changed,
  output logic                          out_ping,
  output logic                          out_reconnect
);
  import rbc_pkg::*;

  // Captured item
  logic [FUNC_W-1:0]   func;
  logic                present;
  logic [CODE_W-1:0]   code;
  logic [TIME_W-1:0]   now;
  logic [RND_W-1:0]    rnd_sh;

  // Persistent state
  logic [MODE_W-1:0]   link_mode, link_mode_next;
  logic [STEP_W-1:0]   retry_step, retry_step_next;
  logic [TIME_W-1:0]   ping_deadline, ping_deadline_next;
  logic [TIME_W-1:0]   retry_deadline, retry_deadline_next;
  logic [HB_W-1:0]     hb_interval;

  // Remainder unit
  logic [REM_W-1:0]    rem, rem_next;
  logic [DIGCNT_W-1:0] digit_cnt;
  logic [REM_W-1:0]    modulus;
  logic [REM_W:0]      partial;

  logic                fatal_code;
  logic                ping, reconnect;
  logic [DELAY_W-1:0]  base;
  logic [OFS_W-1:0]    offset;
  logic [TIME_W-1:0]   now_plus_hb;
  logic [TIME_W-1:0]   ping_age, retry_age;

  always_comb begin
    case (code)
      CLOSE_FATAL_A, CLOSE_FATAL_B, CLOSE_FATAL_C: fatal_code = present;
      default:                                     fatal_code = 1'b0;
    endcase
  end

  assign status.need_mod = (func == FUNC_CLOSED) && !fatal_code;
  assign status.mod_last = (digit_cnt == DIGCNT_W'(DIGITS - 1));

  assign modulus = jitter_mod(retry_step);

  // Restoring remainder, most significant random bits first.
  always_comb begin
    partial = {1'b0, rem};
    for (int k = 0; k < DIGIT_W; k++) begin
      partial = {partial[REM_W-1:0], rnd_sh[RND_W-1-k]};
      if (partial >= {1'b0, modulus}) partial = partial - {1'b0, modulus};
    end
    rem_next = partial[REM_W-1:0];
  end

  assign base        = delay_base(retry_step);
  // base - base/4 + remainder, the jittered delay.
  assign offset      = {1'b0, base} - {3'b000, base[DELAY_W-1:2]} + {2'b00, rem};
  assign now_plus_hb = now + {{(TIME_W-HB_W){1'b0}}, hb_interval};
  assign ping_age    = now - ping_deadline;
  assign retry_age   = now - retry_deadline;

  always_comb begin
    link_mode_next      = link_mode;
    retry_step_next     = retry_step;
    ping_deadline_next  = ping_deadline;
    retry_deadline_next = retry_deadline;
    ping                = 1'b0;
    reconnect           = 1'b0;
    case (func)
      FUNC_OPENED: begin
        retry_step_next    = '0;
        ping_deadline_next = now_plus_hb;
        link_mode_next     = MODE_CONNECTED;
      end
      FUNC_CLOSED: begin
        if (fatal_code) begin
          link_mode_next = MODE_FATAL;
        end else begin
          retry_deadline_next = now + {{(TIME_W-OFS_W){1'b0}}, offset};
          if (retry_step < LAST_STEP) retry_step_next = retry_step + STEP_W'(1);
          link_mode_next = MODE_BACKOFF;
        end
      end
      FUNC_TICK: begin
        // Deadlines are due when the wrapped age is non-negative.
        if (link_mode == MODE_BACKOFF && !retry_age[TIME_W-1]) begin
          reconnect      = 1'b1;
          link_mode_next = MODE_CONNECTING;
        end else if (link_mode == MODE_CONNECTED && !ping_age[TIME_W-1]) begin
          ping               = 1'b1;
          ping_deadline_next = now_plus_hb;
        end
      end
      FUNC_CONNECT: begin
        if (link_mode != MODE_FATAL) begin
          retry_deadline_next = now;
          link_mode_next      = MODE_CONNECTING;
        end
      end
      FUNC_START: link_mode_next = MODE_CONNECTING;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_mode      <= MODE_DISCONNECTED;
      retry_step     <= '0;
      ping_deadline  <= '0;
      retry_deadline <= '0;
      hb_interval    <= HB_RESET;
    end else begin
      if (cfg_we) hb_interval <= cfg_data;
      if (cmd.commit) begin
        link_mode      <= link_mode_next;
        retry_step     <= retry_step_next;
        ping_deadline  <= ping_deadline_next;
        retry_deadline <= retry_deadline_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func      <= in_func;
      present   <= in_present;
      code      <= in_code;
      now       <= in_now;
      rnd_sh    <= in_rnd;
      rem       <= '0;
      digit_cnt <= '0;
    end else if (cmd.mod_step) begin
      rnd_sh    <= {rnd_sh[RND_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      rem       <= rem_next;
      digit_cnt <= digit_cnt + DIGCNT_W'(1);
    end
    if (cmd.commit) begin
      out_state     <= link_mode_next;
      out_changed   <= (link_mode_next != link_mode);
      out_ping      <= ping;
      out_reconnect <= reconnect;
    end
  end

endmodule

[rtl/reconnect_backoff_controller_unit.sv]
// Top level of the reconnect backoff controller: stream ports, config register port.
//
//  Channel   Direction  Handshake          Contents
//  s_*       in         s_tvalid/s_tready  events and ticks (func, close code, time, random)
//  m_*       out        m_tvalid/m_tready  one status result per input transfer
//  cfg_*     in         cfg_we             heartbeat interval in milliseconds
//
// A close that backs off takes longer from input transfer to result than any
// other item, as the remainder unit reduces the random word four bits per
// cycle for the jitter.
// One item is in work at a time; a finished result waits in the output
// register while the next item is taken. Reset is synchronous and sets the
// link to disconnected and the heartbeat interval to 15000 ms.
module reconnect_backoff_controller_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [79:0]                s_tdata,   // close_code, now_ms, random_word
  input  logic [3:0]                 s_tuser,   // func, close_present
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,   // link_state, state_changed,
                                                // send_ping, start_reconnect, zero pad
  input  logic                       cfg_we,
  input  logic [rbc_pkg::HB_W-1:0]   cfg_data
);
  import rbc_pkg::*;

  dp_cmd_t           cmd;
  dp_status_t        status;
  logic [MODE_W-1:0] out_state;
  logic              out_changed;
  logic              out_ping;
  logic              out_reconnect;

  rbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rbc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .in_func       (s_tuser[2:0]),
    .in_present    (s_tuser[3]),
    .in_code       (s_tdata[15:0]),
    .in_now        (s_tdata[47:16]),
    .in_rnd        (s_tdata[79:48]),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .status        (status),
    .out_state     (out_state),
    .out_changed   (out_changed),
    .out_ping      (out_ping),
    .out_reconnect (out_reconnect)
  );

  assign m_tdata = {2'b00, out_reconnect, out_ping, out_changed, out_state};

endmodule
